>>> rtl/eda_pkg.sv
// ----------------------------------------------------------------------------
// eda_pkg
// Shared types and codes of the exclusive device allocation table: request
// and table entry layouts, operation kinds and result status codes.
// ----------------------------------------------------------------------------
package eda_pkg;

	// field widths of a request and of a result
	localparam int KIND_W   = 2;
	localparam int CLASS_W  = 2;
	localparam int JOB_W    = 16;
	localparam int STATUS_W = 2;
	localparam int NUM_W    = 5;

	// stream bus widths, whole bytes
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	// operation kinds
	localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NONE_HELD = 2'd3;

	// one latched request
	typedef struct packed {
		logic [JOB_W-1:0]   job_id;
		logic [CLASS_W-1:0] dev_class;
		logic [KIND_W-1:0]  kind;
	} req_t;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic [CLASS_W-1:0] dev_class;
		logic [JOB_W-1:0]   owner;
		logic [NUM_W-1:0]   rel_no;
	} entry_t;

endpackage

>>> rtl/eda_entry_mem.sv
// ----------------------------------------------------------------------------
// eda_entry_mem
// Entry memory of the allocation table: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module eda_entry_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  eda_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output eda_pkg::entry_t rd_data
);

	eda_pkg::entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/eda_match.sv
// ----------------------------------------------------------------------------
// eda_match
// Shared compare unit: decides whether one table entry satisfies the
// current allocate or release request.
// ----------------------------------------------------------------------------
module eda_match (
	input  eda_pkg::entry_t ent,
	input  logic            used,
	input  eda_pkg::req_t   req,
	output logic            hit
);

	logic class_eq;
	logic owner_eq;

	assign class_eq = (ent.dev_class == req.dev_class);
	assign owner_eq = (ent.owner == req.job_id);

	// allocate wants a free entry, release wants one held by the job
	always_comb begin
		unique case (req.kind)
			eda_pkg::KIND_ALLOC:   hit = class_eq && !used;
			eda_pkg::KIND_RELEASE: hit = class_eq && used && owner_eq;
			default:               hit = 1'b0;
		endcase
	end

endmodule

>>> rtl/exclusive_device_allocator.sv
// ----------------------------------------------------------------------------
// exclusive_device_allocator
// Allocation table of exclusive devices grouped in classes: add, allocate
// and release requests, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis (kind on tuser, dev_class and job_id on tdata);
//   each gives exactly one result on m_axis (status, rel_no, abs_no). One
//   request is worked on at a time; s_axis_tready is high only while the
//   sequencer is idle.
//   Add, unknown kinds and classes out of range skip the scan: the result is
//   set in the decode state and loaded into the output register from done.
//   Allocate and release scan the entry memory from the lowest absolute
//   number, one entry a cycle through the shared compare unit, which sees
//   the registered read data; the scan covers at most the devices added.
//   The scan stops at the first matching entry and updates it in the same
//   cycle: new owner on allocate, used bit on both.
//   The result sits in an output register, so the next request is accepted
//   while it waits; a stalled receiver only holds the sequencer when a second
//   result is ready before the first is taken.
//   Reset empties the table: no devices, all counts zero, no result pending.
//   No clearing pass is needed, entry contents are only read below the count
//   of added devices.
// ----------------------------------------------------------------------------
module exclusive_device_allocator #(
	parameter int MAX_DEVICES = 16,
	parameter int NUM_CLASSES = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// dev_class [1:0], job_id [17:2], zero [23:18]
	input  logic [eda_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// kind [1:0]
	input  logic [eda_pkg::KIND_W-1:0]      s_axis_tuser,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// status [1:0], rel_no [6:2], abs_no [11:7], zero [15:12]
	output logic [eda_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready
);

	localparam int AW  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int CW  = $clog2(MAX_DEVICES + 1);
	localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int NW  = eda_pkg::NUM_W;
	localparam int PAD_W = eda_pkg::OUT_TDATA_W - eda_pkg::STATUS_W - 2 * NW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                         state_q;
	eda_pkg::req_t                  req_q;
	logic [CW-1:0]                  added_q;
	logic [MAX_DEVICES-1:0]         used_q;
	logic [CW-1:0]                  total_q [NUM_CLASSES];
	logic [CW-1:0]                  free_q  [NUM_CLASSES];
	logic [CW-1:0]                  idx_q;
	logic [AW-1:0]                  idx_s1;
	logic                           chk_s1;
	logic [eda_pkg::STATUS_W-1:0]   status_q;
	logic [NW-1:0]                  rel_q;
	logic [NW-1:0]                  abs_q;
	logic                           out_valid_q;
	logic [eda_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic            in_fire;
	logic            out_fire;
	logic            out_load;
	logic            cls_oob;
	logic [CLW-1:0]  cidx;
	logic [CW-1:0]   total_next;
	logic            add_ok;
	logic            rd_en;
	logic            hit;
	logic            scan_hit;
	logic            scan_miss;
	logic            mem_wr_en;
	logic [AW-1:0]   mem_wr_addr;
	eda_pkg::entry_t mem_wr_data;
	eda_pkg::entry_t rd_data;
	logic [CW-1:0]   abs_full;

	// handshakes
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = out_valid_q && m_axis_tready;
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// request decode helpers
	assign cls_oob    = (int'(req_q.dev_class) >= NUM_CLASSES);
	assign cidx       = CLW'(req_q.dev_class);
	assign total_next = total_q[cidx] + CW'(1);
	assign add_ok     = (state_q == S_DECODE) && (req_q.kind == eda_pkg::KIND_ADD) &&
		!cls_oob && (added_q != CW'(MAX_DEVICES));

	// scan control: issue one read a cycle, compare the read data in the next cycle
	assign rd_en     = (state_q == S_SCAN) && (idx_q < added_q);
	assign scan_hit  = (state_q == S_SCAN) && chk_s1 && hit;
	assign scan_miss = (state_q == S_SCAN) && !chk_s1 && !rd_en;
	assign abs_full  = CW'(idx_s1) + CW'(1);

	// entry memory write: new device on add, new owner on allocate
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = added_q[AW-1:0];
		mem_wr_data = '{dev_class: req_q.dev_class, owner: '0, rel_no: NW'(total_next)};
		if (add_ok) begin
			mem_wr_en = 1'b1;
		end else if (scan_hit && (req_q.kind == eda_pkg::KIND_ALLOC)) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = idx_s1;
			mem_wr_data = '{dev_class: rd_data.dev_class, owner: req_q.job_id,
				rel_no: rd_data.rel_no};
		end
	end

	eda_entry_mem #(
		.DEPTH (MAX_DEVICES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	eda_match u_match (
		.ent  (rd_data),
		.used (used_q[idx_s1]),
		.req  (req_q),
		.hit  (hit)
	);

	// sequencer, table counters and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			added_q     <= '0;
			used_q      <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				total_q[c] <= '0;
				free_q[c]  <= '0;
			end
			idx_q       <= '0;
			idx_s1      <= '0;
			chk_s1      <= 1'b0;
			status_q    <= eda_pkg::ST_OK;
			rel_q       <= '0;
			abs_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// output register: load a new result or drop the one taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						req_q.kind      <= s_axis_tuser;
						req_q.dev_class <= s_axis_tdata[1:0];
						req_q.job_id    <= s_axis_tdata[17:2];
						state_q         <= S_DECODE;
					end
				end
				S_DECODE: begin
					rel_q  <= add_ok ? NW'(total_next) : '0;
					abs_q  <= add_ok ? NW'(added_q + CW'(1)) : '0;
					idx_q  <= '0;
					chk_s1 <= 1'b0;
					unique case (req_q.kind)
						eda_pkg::KIND_ADD: begin
							state_q <= S_DONE;
							if (cls_oob) begin
								status_q <= eda_pkg::ST_NO_FREE;
							end else if (added_q == CW'(MAX_DEVICES)) begin
								status_q <= eda_pkg::ST_FULL;
							end else begin
								total_q[cidx]               <= total_next;
								free_q[cidx]                <= free_q[cidx] + CW'(1);
								used_q[added_q[AW-1:0]]     <= 1'b0;
								added_q                     <= added_q + CW'(1);
								status_q                    <= eda_pkg::ST_OK;
							end
						end
						eda_pkg::KIND_ALLOC: begin
							status_q <= eda_pkg::ST_NO_FREE;
							state_q  <= cls_oob ? S_DONE : S_SCAN;
						end
						eda_pkg::KIND_RELEASE: begin
							status_q <= eda_pkg::ST_NONE_HELD;
							state_q  <= cls_oob ? S_DONE : S_SCAN;
						end
						default: begin
							status_q <= eda_pkg::ST_NO_FREE;
							state_q  <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					chk_s1 <= rd_en;
					idx_s1 <= idx_q[AW-1:0];
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end
					if (scan_hit) begin
						// first match wins: take it and update it
						status_q <= eda_pkg::ST_OK;
						rel_q    <= rd_data.rel_no;
						abs_q    <= NW'(abs_full);
						if (req_q.kind == eda_pkg::KIND_ALLOC) begin
							used_q[idx_s1] <= 1'b1;
							if (free_q[cidx] != '0) begin
								free_q[cidx] <= free_q[cidx] - CW'(1);
							end
						end else begin
							used_q[idx_s1] <= 1'b0;
							free_q[cidx]   <= free_q[cidx] + CW'(1);
						end
						state_q <= S_DONE;
					end else if (scan_miss) begin
						status_q <= (req_q.kind == eda_pkg::KIND_ALLOC) ?
							eda_pkg::ST_NO_FREE : eda_pkg::ST_NONE_HELD;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					// hand the result to the output register once it is free
					if (out_load) begin
						out_data_q <= {PAD_W'(0), abs_q, rel_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
